// ===== design/rhc_pkg.sv =====
// Shared types and constants for the RGB to HSL converter.
`timescale 1ns / 1ps
package rhc_pkg;

  // Quotient bits resolved by the divider chain, one per cell
  localparam int QuotBits = 12;
  localparam int RemBits  = 22;
  localparam int DenBits  = 10;

  localparam logic [11:0] HueWrap  = 12'd3600;
  localparam logic [9:0]  LightDen = 10'd1020;

  // One division in flight: running remainder, doubled divisor, quotient so far
  typedef struct packed {
    logic [RemBits-1:0]  rem;
    logic [DenBits-1:0]  den;
    logic [QuotBits-1:0] quot;
  } lane_t;

  // Everything one item carries down the chain
  typedef struct packed {
    lane_t      hue;
    lane_t      sat;
    lane_t      light;
    logic [7:0] alpha;
  } item_t;

endpackage

// ===== design/rhc_front.sv =====
// Front stage: max/min, numerators and divisors for the three divisions.
`timescale 1ns / 1ps
module rhc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    red,
  input  logic [7:0]    green,
  input  logic [7:0]    blue,
  input  logic [7:0]    alpha,
  output logic          out_valid,
  input  logic          out_ready,
  output rhc_pkg::item_t out_item
);
  import rhc_pkg::*;

  logic [7:0]         mx, mn, d;
  logic [8:0]         s;
  logic               red_max, green_max;
  logic signed [9:0]  diff;
  logic signed [21:0] prod, base, num;
  logic [8:0]         sat_den;
  item_t              item_next;

  // Max and min, red winning ties over green, green over blue
  always_comb begin
    red_max   = (red >= green) && (red >= blue);
    green_max = !red_max && (green >= blue);
    mx = red_max ? red : (green_max ? green : blue);
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    d = mx - mn;
    s = {1'b0, mx} + {1'b0, mn};
  end

  // Hue numerator in tenths, kept non-negative
  always_comb begin
    if (red_max) begin
      diff = $signed({2'b00, green}) - $signed({2'b00, blue});
      base = '0;
    end else if (green_max) begin
      diff = $signed({2'b00, blue}) - $signed({2'b00, red});
      base = $signed(22'(d) * 22'd1200);
    end else begin
      diff = $signed({2'b00, red}) - $signed({2'b00, green});
      base = $signed(22'(d) * 22'd2400);
    end
    prod = 22'(diff) * 22'sd600;
    num  = base + prod;
    if (num < 0) num = num + $signed(22'(d) * 22'd3600);
    sat_den = (s < 9'd255) ? s : (9'd510 - s);
  end

  // Round-to-nearest set up as floor((2n + den) / (2den))
  always_comb begin
    item_next.alpha       = alpha;
    item_next.light.rem   = 22'(s) * 22'd2000 + 22'(LightDen >> 1);
    item_next.light.den   = LightDen;
    item_next.light.quot  = '0;
    item_next.hue.quot    = '0;
    item_next.sat.quot    = '0;
    if (d == 8'd0) begin
      // grey pixel: hue and saturation are zero
      item_next.hue.rem = '0;
      item_next.hue.den = 10'd1;
      item_next.sat.rem = '0;
      item_next.sat.den = 10'd1;
    end else begin
      item_next.hue.rem = 22'(unsigned'(num) << 1) + 22'(d);
      item_next.hue.den = {1'b0, d, 1'b0};
      item_next.sat.rem = 22'(d) * 22'd2000 + 22'(sat_den);
      item_next.sat.den = {sat_den, 1'b0};
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

// ===== design/rhc_cell.sv =====
// Divider cell: resolves one quotient bit of all three divisions.
`timescale 1ns / 1ps
module rhc_cell #(
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rhc_pkg::item_t in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output rhc_pkg::item_t out_item
);
  import rhc_pkg::*;

  item_t item_next;

  // Restoring step on one lane
  function automatic lane_t step(lane_t l);
    logic [RemBits-1:0] dsh;
    lane_t              r;
    dsh = RemBits'(l.den) << SHIFT;
    r   = l;
    if (l.rem >= dsh) begin
      r.rem = l.rem - dsh;
      r.quot[SHIFT] = 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    item_next       = in_item;
    item_next.hue   = step(in_item.hue);
    item_next.sat   = step(in_item.sat);
    item_next.light = step(in_item.light);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

// ===== design/rgb_to_hsl_converter_core.sv =====
// Top level: front stage followed by a chain of divider cells.
//
//  channel   | direction | tdata fields (low bit up)
//  s_axis    | in        | red, green, blue, alpha (32 bits)
//  m_axis    | out       | hue_tenths, saturation_tenths, lightness_tenths,
//            |           | alpha_out (40 bits)
//
// One item per clock sustained while the output accepts; front stage plus 12
// cells, one quotient bit per cell. Each stage holds one item with its own
// valid, so bubbles close up while the output is stalled.
// Synchronous reset empties all stages.
`timescale 1ns / 1ps
module rgb_to_hsl_converter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // red, green, blue, alpha
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // hue, saturation, lightness, alpha_out
);
  import rhc_pkg::*;

  logic  [QuotBits:0] vld;
  logic  [QuotBits:0] rdy;
  item_t              itm [QuotBits+1];
  logic [11:0]        hue_raw, hue;

  rhc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .red       (s_axis_tdata[7:0]),
    .green     (s_axis_tdata[15:8]),
    .blue      (s_axis_tdata[23:16]),
    .alpha     (s_axis_tdata[31:24]),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_item  (itm[0])
  );

  // Cells resolve quotient bits from the top down
  for (genvar k = 0; k < QuotBits; k++) begin : g_cell
    rhc_cell #(.SHIFT(QuotBits - 1 - k)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[k]),
      .in_ready  (rdy[k]),
      .in_item   (itm[k]),
      .out_valid (vld[k+1]),
      .out_ready (rdy[k+1]),
      .out_item  (itm[k+1])
    );
  end

  assign rdy[QuotBits] = m_axis_tready;
  assign m_axis_tvalid = vld[QuotBits];

  // Hue rounding up to a full turn wraps to zero
  assign hue_raw = itm[QuotBits].hue.quot;
  assign hue     = (hue_raw >= HueWrap) ? 12'd0 : hue_raw;

  assign m_axis_tdata = {itm[QuotBits].alpha,
                         itm[QuotBits].light.quot[9:0],
                         itm[QuotBits].sat.quot[9:0],
                         hue};

endmodule

// ===== design/rhc_checker.sv =====
// Port-level checks on the converter, bound to the top level.
`timescale 1ns / 1ps
module rhc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // Hue never reaches a full turn
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[11:0] < 12'd3600)
    else $error("hue out of range");

  // Saturation at most one thousand tenths
  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[21:12] <= 10'd1000)
    else $error("saturation out of range");

  // Lightness at most one thousand tenths
  a_light_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[31:22] <= 10'd1000)
    else $error("lightness out of range");

  // A stalled result holds its item
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed under stall");

  // Input only backs up while a result is held at the output
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled with the output free");

endmodule

bind rgb_to_hsl_converter_core rhc_checker u_rhc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
